### src/assert_macros.svh
// Assertion macros used by the checker file of this block.
// Depends on nothing; included by name where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on the rising clock edge, suspended while reset is low.
`define EPDR_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every rising clock edge, including during reset.
`define EPDR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/epdr_pkg.sv
// Package for the exponential-error PWM duty regulator.
// Holds widths, the ratio table builder and the item type between stages.
`timescale 1ns / 1ps
`default_nettype none

package epdr_pkg;

    localparam int TEMP_W  = 12;
    localparam int DIFF_W  = 13;
    localparam int RATIO_W = 17;
    localparam int DUTY_W  = 16;

    localparam int unsigned DUTY_TOP_DEF = 65535;

    localparam int D_MIN     = -2048;
    localparam int D_LIMIT   = 400;
    localparam int ROM_DEPTH = D_LIMIT - D_MIN + 1;
    localparam int ADDR_W    = $clog2(ROM_DEPTH);

    localparam longint LOG2E_Q16_DIV160 = 591;
    localparam longint unsigned LN2_Q30 = 64'd744261118;
    localparam longint COEF_Q20 = 392797;
    localparam longint unsigned ONE_Q30 = 64'd1 << 30;
    localparam longint unsigned RATIO_SAT = 64'd65535;
    localparam int TAYLOR_TERMS = 12;

    typedef logic signed [RATIO_W-1:0] t_ratio;
    typedef t_ratio t_ratio_rom [ROM_DEPTH];

    typedef struct packed {
        logic   valid;
        logic   mode;
        t_ratio ratio;
    } t_ratio_item;

    // Shift and subtract quotient, used only while the table is built.
    function automatic longint unsigned div_by_index(input longint unsigned num,
                                                     input longint unsigned den);
        longint unsigned quo;
        longint unsigned rem;
        quo = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[62:0], num[b]};
            if (rem >= den) begin
                rem = rem - den;
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    function automatic t_ratio_rom build_ratio_rom();
        t_ratio_rom rom;
        longint y;
        longint n;
        longint f;
        longint p;
        longint unsigned t;
        longint unsigned term;
        longint unsigned sum;
        longint unsigned e;
        longint unsigned mag;
        longint unsigned q;
        for (int d = D_MIN; d <= D_LIMIT; d++) begin
            y = longint'(d) * LOG2E_Q16_DIV160;
            n = y >>> 16;
            f = y & 64'hFFFF;
            t = (longint'(f) * LN2_Q30) >> 16;
            term = ONE_Q30;
            sum = ONE_Q30;
            for (int k = 1; k <= TAYLOR_TERMS; k++) begin
                term = div_by_index((term * t) >> 30, 64'(k));
                sum = sum + term;
            end
            if (n >= 0) begin
                e = sum << n;
            end else begin
                e = sum >> (-n);
            end
            p = (longint'(e) - longint'(ONE_Q30)) * COEF_Q20;
            mag = (p < 0) ? longint'(-p) : longint'(p);
            q = (mag + (64'd1 << 34)) >> 35;
            if (p >= 0) begin
                rom[d - D_MIN] = (q > RATIO_SAT) ? t_ratio'(RATIO_SAT) : t_ratio'(q);
            end else begin
                rom[d - D_MIN] = -t_ratio'(q);
            end
        end
        return rom;
    endfunction

endpackage

`default_nettype wire

### src/epdr_ratio_lookup.sv
// Ratio lookup: temperature difference register, then registered table read.
// Depends on epdr_pkg for widths, the table builder and the item type.
`timescale 1ns / 1ps
`default_nettype none

module epdr_ratio_lookup (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_advance,
    input  wire logic                                  i_valid,
    input  wire logic signed [epdr_pkg::TEMP_W-1:0]    i_temp_measured,
    input  wire logic signed [epdr_pkg::TEMP_W-1:0]    i_temp_target,
    input  wire logic                                  i_mode,
    output epdr_pkg::t_ratio_item                      o_item
);

    localparam epdr_pkg::t_ratio_rom RATIO_ROM = epdr_pkg::build_ratio_rom();
    localparam logic signed [epdr_pkg::DIFF_W-1:0] D_MIN_S =
        epdr_pkg::DIFF_W'(epdr_pkg::D_MIN);
    localparam logic signed [epdr_pkg::DIFF_W-1:0] D_LIMIT_S =
        epdr_pkg::DIFF_W'(epdr_pkg::D_LIMIT);

    logic signed [epdr_pkg::DIFF_W-1:0] diff;
    logic signed [epdr_pkg::DIFF_W-1:0] diff_clamped;
    logic signed [epdr_pkg::DIFF_W-1:0] offset;
    logic [epdr_pkg::ADDR_W-1:0]        n_addr;

    logic                        r_a_valid;
    logic                        r_a_mode;
    logic [epdr_pkg::ADDR_W-1:0] r_a_addr;
    logic                        r_b_valid;
    logic                        r_b_mode;
    epdr_pkg::t_ratio            r_b_ratio;

    always_comb begin
        diff = {i_temp_measured[epdr_pkg::TEMP_W-1], i_temp_measured}
             - {i_temp_target[epdr_pkg::TEMP_W-1], i_temp_target};
        if (diff > D_LIMIT_S) begin
            diff_clamped = D_LIMIT_S;
        end else if (diff < D_MIN_S) begin
            diff_clamped = D_MIN_S;
        end else begin
            diff_clamped = diff;
        end
        offset = diff_clamped - D_MIN_S;
        n_addr = offset[epdr_pkg::ADDR_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else if (i_advance) begin
            r_a_valid <= i_valid;
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_a_mode  <= i_mode;
            r_a_addr  <= n_addr;
            r_b_mode  <= r_a_mode;
            r_b_ratio <= RATIO_ROM[r_a_addr];
        end
    end

    assign o_item.valid = r_b_valid;
    assign o_item.mode  = r_b_mode;
    assign o_item.ratio = r_b_ratio;

endmodule

`default_nettype wire

### src/epdr_duty_update.sv
// Duty update: sign-change halving, mode clamp, duty scaling and state registers.
// Depends on epdr_pkg for widths and the item type.
`timescale 1ns / 1ps
`default_nettype none

module epdr_duty_update #(
    parameter int unsigned DUTY_TOP = epdr_pkg::DUTY_TOP_DEF
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_advance,
    input  wire epdr_pkg::t_ratio_item                 i_item,
    output logic                                       o_valid,
    output logic [epdr_pkg::DUTY_W-1:0]                o_duty,
    output logic signed [epdr_pkg::RATIO_W-1:0]        o_step_ratio
);

    localparam int RW    = epdr_pkg::RATIO_W;
    localparam int DW    = epdr_pkg::DUTY_W;
    localparam int PROD_W = 2 * RW;
    localparam int NUM_W  = PROD_W + 1;
    localparam int Q_W    = NUM_W - 15;

    localparam logic signed [RW-1:0] DUTY_TOP_S = RW'(DUTY_TOP);
    localparam logic signed [RW-1:0] RATIO_ONE  = RW'(32768);
    localparam logic [Q_W-1:0]       DUTY_TOP_Q = Q_W'(DUTY_TOP);
    localparam logic [DW-1:0]        DUTY_TOP_D = DW'(DUTY_TOP);

    logic                     in_pos;
    logic                     last_pos;
    logic                     sign_flip;
    logic signed [RW:0]       ratio_bias;
    logic signed [RW-1:0]     ratio_sel;
    logic signed [RW-1:0]     ratio_abs;
    logic signed [RW-1:0]     n_ratio;
    logic signed [PROD_W-1:0] product;
    logic signed [NUM_W-1:0]  duty_term;
    logic signed [NUM_W-1:0]  num;
    logic [Q_W-1:0]           num_q;
    logic [DW-1:0]            n_duty;

    logic                     r_valid;
    logic signed [RW-1:0]     r_last_ratio;
    logic [DW-1:0]            r_duty_level;

    always_comb begin
        in_pos    = !i_item.ratio[RW-1] && (|i_item.ratio);
        last_pos  = !r_last_ratio[RW-1] && (|r_last_ratio);
        sign_flip = (in_pos && r_last_ratio[RW-1]) || (i_item.ratio[RW-1] && last_pos);

        ratio_bias = $signed({i_item.ratio[RW-1], i_item.ratio})
                   + $signed({{RW{1'b0}}, i_item.ratio[RW-1]});
        ratio_sel  = sign_flip ? ratio_bias[RW:1] : i_item.ratio;

        if (ratio_sel[RW-1]) begin
            ratio_abs = '0;
        end else if (ratio_sel > RATIO_ONE) begin
            ratio_abs = RATIO_ONE;
        end else begin
            ratio_abs = ratio_sel;
        end
        n_ratio = i_item.mode ? ratio_sel : ratio_abs;

        product   = DUTY_TOP_S * n_ratio;
        duty_term = i_item.mode ? $signed({{(NUM_W-DW-15){1'b0}}, r_duty_level, 15'b0})
                                : '0;
        num       = duty_term + $signed({product[PROD_W-1], product});
        num_q     = num[NUM_W-1:15];

        if (num[NUM_W-1] || (num == '0)) begin
            n_duty = '0;
        end else if (num_q > DUTY_TOP_Q) begin
            n_duty = DUTY_TOP_D;
        end else begin
            n_duty = num_q[DW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_last_ratio <= '0;
            r_duty_level <= '0;
        end else if (i_advance) begin
            r_valid <= i_item.valid;
            if (i_item.valid) begin
                r_last_ratio <= n_ratio;
                r_duty_level <= n_duty;
            end
        end
    end

    assign o_valid      = r_valid;
    assign o_duty       = r_duty_level;
    assign o_step_ratio = r_last_ratio;

endmodule

`default_nettype wire

### src/exp_error_pwm_duty_regulator.sv
// Top level of the exponential-error PWM duty regulator.
// Depends on epdr_pkg, epdr_ratio_lookup and epdr_duty_update.
//
// Channel   Direction  Handshake                  Payload
// input     in         i_in_valid / o_in_ready    i_temp_measured, i_temp_target, i_mode
// result    out        o_out_valid / i_out_ready  o_duty, o_step_ratio
//
// One item is accepted per cycle while the pipeline does not hold; its result is
// registered through each stage in turn, so up to three items are in flight.
// The stages are the difference register, the registered ratio table read,
// and the duty update whose result registers also hold the regulator state.
// The whole pipeline holds while a result waits and i_out_ready is low.
// Reset clears the stage valid bits, the stored ratio and the duty level.
`timescale 1ns / 1ps
`default_nettype none

module exp_error_pwm_duty_regulator #(
    parameter int unsigned DUTY_TOP = epdr_pkg::DUTY_TOP_DEF
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_in_valid,
    output logic                                       o_in_ready,
    input  wire logic signed [epdr_pkg::TEMP_W-1:0]    i_temp_measured,
    input  wire logic signed [epdr_pkg::TEMP_W-1:0]    i_temp_target,
    input  wire logic                                  i_mode,
    output logic                                       o_out_valid,
    input  wire logic                                  i_out_ready,
    output logic [epdr_pkg::DUTY_W-1:0]                o_duty,
    output logic signed [epdr_pkg::RATIO_W-1:0]        o_step_ratio
);

    logic                  advance;
    epdr_pkg::t_ratio_item ratio_item;

    assign advance    = !o_out_valid || i_out_ready;
    assign o_in_ready = advance;

    epdr_ratio_lookup u_lookup (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_advance       (advance),
        .i_valid         (i_in_valid),
        .i_temp_measured (i_temp_measured),
        .i_temp_target   (i_temp_target),
        .i_mode          (i_mode),
        .o_item          (ratio_item)
    );

    epdr_duty_update #(
        .DUTY_TOP (DUTY_TOP)
    ) u_update (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_advance    (advance),
        .i_item       (ratio_item),
        .o_valid      (o_out_valid),
        .o_duty       (o_duty),
        .o_step_ratio (o_step_ratio)
    );

endmodule

`default_nettype wire

### src/epdr_checker.sv
// Port-level checks for the duty regulator, attached to the top level by bind.
// Depends on assert_macros.svh and epdr_pkg.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module epdr_checker (
    input wire logic                                  i_clk,
    input wire logic                                  i_rst_n,
    input wire logic                                  i_in_ready,
    input wire logic                                  i_out_valid,
    input wire logic                                  i_out_ready,
    input wire logic [epdr_pkg::DUTY_W-1:0]           i_duty,
    input wire logic signed [epdr_pkg::RATIO_W-1:0]   i_step_ratio
);

    localparam logic signed [epdr_pkg::RATIO_W-1:0] RATIO_FLOOR = -17'sd12275;

    `EPDR_ASSERT_ALWAYS(a_reset_clears_out, i_clk, !i_rst_n |=> !i_out_valid, "result valid after reset")
    `EPDR_ASSERT(a_ready_when_empty, i_clk, i_rst_n, !i_out_valid |-> i_in_ready, "input stalled with no result waiting")
    `EPDR_ASSERT(a_ratio_floor, i_clk, i_rst_n, i_out_valid |-> (i_step_ratio >= RATIO_FLOOR), "step ratio below table floor")
    `EPDR_ASSERT(a_stall_holds, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_duty) && $stable(i_step_ratio), "stalled result changed")

endmodule

bind exp_error_pwm_duty_regulator epdr_checker u_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_ready   (o_in_ready),
    .i_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .i_duty       (o_duty),
    .i_step_ratio (o_step_ratio)
);

`default_nettype wire

### dv/exp_error_pwm_duty_regulator_tb.sv
// Self-checking testbench for the exponential-error PWM duty regulator.
// Predicts duty and step ratio per item and checks every result in order.
// Depends on epdr_pkg and the exp_error_pwm_duty_regulator RTL.
`timescale 1ns / 1ps

module exp_error_pwm_duty_regulator_tb;

    typedef longint unsigned t_u64;
    typedef logic signed [epdr_pkg::TEMP_W-1:0] t_temp;

    typedef struct packed {
        logic [epdr_pkg::DUTY_W-1:0] duty;
        epdr_pkg::t_ratio            ratio;
    } t_duty_result;

    localparam logic MODE_ABS = 1'b0;
    localparam logic MODE_INC = 1'b1;

    localparam int     DUTY_FULL    = int'(epdr_pkg::DUTY_TOP_DEF);
    localparam int     RATIO_UNITY  = 32768;
    localparam int     RATIO_CEIL   = 65535;
    localparam int     DIFF_CAP     = 400;
    localparam longint LOG2E_DIV160 = 591;
    localparam t_u64   LN2_FRAC     = 64'd744261118;
    localparam longint GAIN_FRAC    = 392797;
    localparam longint EXP_ONE      = longint'(1) << 30;
    localparam int     SERIES_LEN   = 12;
    localparam int     CYCLE_LIMIT  = 200000;
    localparam int     RANDOM_ITEMS = 800;
    localparam int     QUIET_ITEMS  = 120;

    logic  i_clk = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  i_in_valid = 1'b0;
    logic  o_in_ready;
    t_temp i_temp_measured = '0;
    t_temp i_temp_target = '0;
    logic  i_mode = MODE_ABS;
    logic  o_out_valid;
    logic  i_out_ready = 1'b0;
    logic [epdr_pkg::DUTY_W-1:0] o_duty;
    epdr_pkg::t_ratio o_step_ratio;

    t_duty_result expected_results[$];
    int   held_duty_level = 0;
    int   held_last_ratio = 0;
    int   mismatch_count = 0;
    int   cycle_count = 0;
    int   sink_hold_req = 0;
    bit   src_idle_on = 1'b0;
    bit   sink_idle_on = 1'b0;

    exp_error_pwm_duty_regulator #(
        .DUTY_TOP(DUTY_FULL)
    ) u_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_temp_measured(i_temp_measured),
        .i_temp_target(i_temp_target),
        .i_mode(i_mode),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_duty(o_duty),
        .o_step_ratio(o_step_ratio)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("exp_error_pwm_duty_regulator_tb: FAIL");
        $finish;
    end

    function automatic int exp_step_ratio(input int diff);
        longint y;
        longint n;
        longint f;
        longint p;
        t_u64   t;
        t_u64   term;
        t_u64   sum;
        t_u64   e;
        t_u64   mag;
        t_u64   q;
        if (diff > DIFF_CAP) begin
            diff = DIFF_CAP;
        end
        y = longint'(diff) * LOG2E_DIV160;
        n = y >>> 16;
        f = y - (n <<< 16);
        t = (t_u64'(f) * LN2_FRAC) >> 16;
        term = t_u64'(EXP_ONE);
        sum = t_u64'(EXP_ONE);
        for (int k = 1; k <= SERIES_LEN; k++) begin
            term = ((term * t) >> 30) / t_u64'(k);
            sum = sum + term;
        end
        e = (n >= 0) ? (sum << n) : (sum >> (-n));
        p = (longint'(e) - EXP_ONE) * GAIN_FRAC;
        mag = (p < 0) ? t_u64'(-p) : t_u64'(p);
        q = (mag + (t_u64'(1) << 34)) >> 35;
        if (p >= 0) begin
            return (q > t_u64'(RATIO_CEIL)) ? RATIO_CEIL : int'(q);
        end
        return -int'(q);
    endfunction

    function automatic t_duty_result regulate_step(input t_temp meas, input t_temp targ,
                                                   input logic mode);
        t_duty_result res;
        int           r;
        longint       acc;
        longint       nd;
        r = exp_step_ratio(int'(meas) - int'(targ));
        if ((r > 0 && held_last_ratio < 0) || (r < 0 && held_last_ratio > 0)) begin
            r = (r < 0) ? -((-r) >> 1) : (r >> 1);
        end
        if (mode == MODE_INC) begin
            acc = longint'(held_duty_level) * RATIO_UNITY + longint'(DUTY_FULL) * r;
        end else begin
            if (r < 0) begin
                r = 0;
            end
            if (r > RATIO_UNITY) begin
                r = RATIO_UNITY;
            end
            acc = longint'(DUTY_FULL) * r;
        end
        if (acc <= 0) begin
            nd = 0;
        end else begin
            nd = acc >>> 15;
            if (nd > DUTY_FULL) begin
                nd = DUTY_FULL;
            end
        end
        held_last_ratio = r;
        held_duty_level = int'(nd);
        res.duty = nd[epdr_pkg::DUTY_W-1:0];
        res.ratio = epdr_pkg::t_ratio'(r);
        return res;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatch_count++;
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    task automatic send_reading(input t_temp meas, input t_temp targ, input logic mode);
        if (src_idle_on && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_temp_measured <= meas;
        i_temp_target <= targ;
        i_mode <= mode;
        do @(negedge i_clk); while (!o_in_ready);
        expected_results.push_back(regulate_step(meas, targ, mode));
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
    endtask

    function automatic t_temp clip_temp(input int v);
        if (v > 2047) begin
            return t_temp'(2047);
        end
        if (v < -2048) begin
            return t_temp'(-2048);
        end
        return t_temp'(v);
    endfunction

    // Output side: random stalls, plus a long hold when one is requested.
    initial begin : sink_driver
        int hold_len;
        int hold_cnt;
        @(posedge i_clk);
        forever begin
            if (sink_hold_req > 0) begin
                hold_len = sink_hold_req;
                sink_hold_req = 0;
                i_out_ready <= 1'b0;
                for (hold_cnt = 0; hold_cnt < hold_len; hold_cnt++) @(posedge i_clk);
            end else if (sink_idle_on && $urandom_range(0, 4) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    initial begin : result_checker
        t_duty_result want;
        forever begin
            @(negedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result duty", o_duty, -1);
                end else begin
                    want = expected_results.pop_front();
                    if (o_duty !== want.duty) begin
                        report_mismatch("duty", o_duty, want.duty);
                    end
                    if (o_step_ratio !== want.ratio) begin
                        report_mismatch("step_ratio", o_step_ratio, want.ratio);
                    end
                end
            end
        end
    end

    task automatic test_directed_extremes();
        send_reading(t_temp'(0), t_temp'(0), MODE_INC);
        send_reading(t_temp'(2047), t_temp'(-2048), MODE_INC);
        repeat (5) send_reading(t_temp'(-2048), t_temp'(2047), MODE_INC);
        send_reading(t_temp'(-2048), t_temp'(2047), MODE_ABS);
        send_reading(t_temp'(296), t_temp'(0), MODE_ABS);
        send_reading(t_temp'(295), t_temp'(0), MODE_INC);
        send_reading(t_temp'(400), t_temp'(0), MODE_INC);
        send_reading(t_temp'(401), t_temp'(0), MODE_INC);
        send_reading(t_temp'(2047), t_temp'(2047), MODE_ABS);
        send_reading(t_temp'(-2048), t_temp'(-2048), MODE_INC);
        send_reading(t_temp'(1), t_temp'(0), MODE_INC);
        send_reading(t_temp'(0), t_temp'(1), MODE_INC);
        send_reading(t_temp'(1365), t_temp'(-1366), MODE_ABS);
        send_reading(t_temp'(-1366), t_temp'(1365), MODE_INC);
        send_reading(t_temp'(-160), t_temp'(0), MODE_ABS);
        send_reading(t_temp'(160), t_temp'(0), MODE_INC);
        send_reading(t_temp'(2047), t_temp'(0), MODE_INC);
        send_reading(t_temp'(0), t_temp'(-2048), MODE_ABS);
    endtask

    task automatic test_sign_changes();
        int    mag;
        t_temp targ;
        for (int i = 0; i < 24; i++) begin
            mag = (i % 7 == 6) ? 0 : int'($urandom_range(1, 200));
            targ = clip_temp(int'($urandom_range(0, 1000)) - 500);
            send_reading(clip_temp(int'(targ) + ((i % 2 == 0) ? mag : -mag)), targ,
                         (i % 5 == 4) ? MODE_ABS : MODE_INC);
        end
    endtask

    task automatic test_backpressure();
        sink_hold_req = 150;
        for (int i = 0; i < 20; i++) begin
            send_reading(t_temp'($urandom), t_temp'($urandom), logic'($urandom_range(0, 1)));
        end
        wait_drained();
    endtask

    task automatic test_random_regulation();
        int    sel;
        t_temp meas;
        t_temp targ;
        logic  mode;
        src_idle_on = 1'b1;
        sink_idle_on = 1'b1;
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == RANDOM_ITEMS - QUIET_ITEMS) begin
                src_idle_on = 1'b0;
                sink_idle_on = 1'b0;
            end
            sel = $urandom_range(0, 9);
            targ = t_temp'($urandom);
            if (sel < 5) begin
                meas = clip_temp(int'(targ) + int'($urandom_range(0, 720)) - 300);
            end else if (sel < 7) begin
                meas = clip_temp(int'(targ) + int'($urandom_range(0, 40)) - 20);
            end else begin
                meas = t_temp'($urandom);
            end
            mode = ($urandom_range(0, 3) != 0) ? MODE_INC : MODE_ABS;
            send_reading(meas, targ, mode);
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_extremes();
        test_sign_changes();
        test_backpressure();
        test_random_regulation();
        wait_drained();
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("exp_error_pwm_duty_regulator_tb: PASS");
        end else begin
            $display("exp_error_pwm_duty_regulator_tb: FAIL");
        end
        $finish;
    end

endmodule
